>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Hold a condition at every edge.
`define FBIK_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a consequence in the same cycle.
`define FBIK_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the next cycle.
`define FBIK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/fbik_pkg.sv
// ----------------------------------------------------------------------------
// Five-bar IK package
// Constants, register indexes, status codes and the arctangent table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fbik_pkg;

  localparam int LEN_W     = 18;
  localparam int CFG_IDX_W = 3;
  localparam int STATUS_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_CRANK   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_DISTAL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_DISTAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_CRANK  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE         = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK            = 2'd0;
  localparam logic [STATUS_W-1:0] ST_LEFT_UNREACH  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RIGHT_UNREACH = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DEGENERATE    = 2'd3;

  localparam int CORDIC_MAG_W = 41;
  localparam int ANGLE_ACC_W  = 32;
  localparam int ATAN_N       = 24;

  localparam logic [31:0] ATAN_TAB [ATAN_N] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef struct packed {
    logic valid;
    logic unreach;
    logic degen;
  } arm_stat_t;

endpackage

>>> sv/fbik_arm.sv
// ----------------------------------------------------------------------------
// Five-bar IK arm solver
// Pipelined solve of one crank: quadratic coefficients, discriminant,
// bit-per-stage square root, normalization and a vectoring CORDIC.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbik_arm #(
  parameter int CW    = 20,
  parameter int AW    = 16,
  parameter int CS    = 16,
  parameter bit RIGHT = 1'b0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [CW-1:0]          x,
  input  logic signed [CW-1:0]          y,
  input  logic [fbik_pkg::LEN_W-1:0]    base,
  input  logic [fbik_pkg::LEN_W-1:0]    crank,
  input  logic [fbik_pkg::LEN_W-1:0]    distal,
  output fbik_pkg::arm_stat_t           res,
  output logic [AW-1:0]                 angle
);

  localparam int LW  = fbik_pkg::LEN_W;
  localparam int EW  = ((CW > LW) ? CW : LW) + 4;
  localparam int TW  = 2 * EW;
  localparam int FW  = 4 * EW;
  localparam int DW  = FW + 4;
  localparam int RW  = DW / 2;
  localparam int RMW = RW + 2;
  localparam int NW  = TW + 3;
  localparam int L   = $clog2(NW);
  localparam int MW  = fbik_pkg::CORDIC_MAG_W;
  localparam int CXW = MW + 3;
  localparam int ZW  = fbik_pkg::ANGLE_ACC_W + 2;
  localparam int SHA = fbik_pkg::ANGLE_ACC_W - AW;
  localparam logic [ZW:0] RND = (ZW + 1)'(1) << (SHA - 1);

  // stage 1: arm frame
  logic signed [EW-1:0] x2, bs, r2, xa;
  logic signed [EW-1:0] s1_p_r, s1_q_r, s1_y_r, s1_r_r, s1_d_r;
  fbik_pkg::arm_stat_t  s1_st_r, s1_st_nxt;

  always_comb begin
    x2 = EW'(x) <<< 1;
    bs = signed'(EW'(base));
    r2 = signed'(EW'(crank)) <<< 1;
    if (RIGHT) begin
      xa = x2 - bs;
    end else begin
      xa = x2 + bs;
    end
    s1_st_nxt = '{valid: in_valid, unreach: 1'b0, degen: 1'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_p_r <= xa + r2;
      s1_q_r <= xa - r2;
      s1_y_r <= EW'(y) <<< 1;
      s1_r_r <= r2;
      s1_d_r <= signed'(EW'(distal)) <<< 1;
    end
  end

  // stage 2: squares
  logic signed [TW-1:0] s2_pp_r, s2_qq_r, s2_yy_r, s2_dd_r, s2_ry_r;
  fbik_pkg::arm_stat_t  s2_st_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_pp_r <= TW'(s1_p_r) * TW'(s1_p_r);
      s2_qq_r <= TW'(s1_q_r) * TW'(s1_q_r);
      s2_yy_r <= TW'(s1_y_r) * TW'(s1_y_r);
      s2_dd_r <= TW'(s1_d_r) * TW'(s1_d_r);
      s2_ry_r <= TW'(s1_r_r) * TW'(s1_y_r);
    end
  end

  // stage 3: coefficients
  logic signed [TW-1:0] s3_a_r, s3_c_r, s3_nb_r;
  fbik_pkg::arm_stat_t  s3_st_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_a_r  <= s2_pp_r + s2_yy_r - s2_dd_r;
      s3_c_r  <= s2_qq_r + s2_yy_r - s2_dd_r;
      s3_nb_r <= s2_ry_r <<< 2;
    end
  end

  // stage 4: magnitudes
  logic [TW-1:0]        s4_am_r, s4_cm_r, s4_bm_r;
  logic                 s4_aneg_r, s4_acneg_r;
  logic signed [TW-1:0] s4_nb_r;
  fbik_pkg::arm_stat_t  s4_st_r, s4_st_nxt;

  always_comb begin
    s4_st_nxt       = s3_st_r;
    s4_st_nxt.degen = (s3_a_r == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_am_r    <= s3_a_r[TW-1] ? TW'(-s3_a_r) : TW'(s3_a_r);
      s4_cm_r    <= s3_c_r[TW-1] ? TW'(-s3_c_r) : TW'(s3_c_r);
      s4_bm_r    <= s3_nb_r[TW-1] ? TW'(-s3_nb_r) : TW'(s3_nb_r);
      s4_aneg_r  <= s3_a_r[TW-1];
      s4_acneg_r <= s3_a_r[TW-1] ^ s3_c_r[TW-1];
      s4_nb_r    <= s3_nb_r;
    end
  end

  // stage 5: partial products
  logic [TW-1:0]        s5_ac_ll_r, s5_ac_lh_r, s5_ac_hl_r, s5_ac_hh_r;
  logic [TW-1:0]        s5_bb_ll_r, s5_bb_lh_r, s5_bb_hh_r;
  logic [TW-1:0]        s5_am_r;
  logic                 s5_aneg_r, s5_acneg_r;
  logic signed [TW-1:0] s5_nb_r;
  fbik_pkg::arm_stat_t  s5_st_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_ac_ll_r <= TW'(s4_am_r[EW-1:0])  * TW'(s4_cm_r[EW-1:0]);
      s5_ac_lh_r <= TW'(s4_am_r[EW-1:0])  * TW'(s4_cm_r[TW-1:EW]);
      s5_ac_hl_r <= TW'(s4_am_r[TW-1:EW]) * TW'(s4_cm_r[EW-1:0]);
      s5_ac_hh_r <= TW'(s4_am_r[TW-1:EW]) * TW'(s4_cm_r[TW-1:EW]);
      s5_bb_ll_r <= TW'(s4_bm_r[EW-1:0])  * TW'(s4_bm_r[EW-1:0]);
      s5_bb_lh_r <= TW'(s4_bm_r[EW-1:0])  * TW'(s4_bm_r[TW-1:EW]);
      s5_bb_hh_r <= TW'(s4_bm_r[TW-1:EW]) * TW'(s4_bm_r[TW-1:EW]);
      s5_am_r    <= s4_am_r;
      s5_aneg_r  <= s4_aneg_r;
      s5_acneg_r <= s4_acneg_r;
      s5_nb_r    <= s4_nb_r;
    end
  end

  // stage 6: partial sums
  logic [FW-1:0]        s6_ac_cat_r, s6_bb_cat_r;
  logic [TW:0]          s6_ac_mid_r, s6_bb_mid_r;
  logic [TW-1:0]        s6_am_r;
  logic                 s6_aneg_r, s6_acneg_r;
  logic signed [TW-1:0] s6_nb_r;
  fbik_pkg::arm_stat_t  s6_st_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_ac_cat_r <= {s5_ac_hh_r, s5_ac_ll_r};
      s6_bb_cat_r <= {s5_bb_hh_r, s5_bb_ll_r};
      s6_ac_mid_r <= (TW + 1)'(s5_ac_lh_r) + (TW + 1)'(s5_ac_hl_r);
      s6_bb_mid_r <= {s5_bb_lh_r, 1'b0};
      s6_am_r     <= s5_am_r;
      s6_aneg_r   <= s5_aneg_r;
      s6_acneg_r  <= s5_acneg_r;
      s6_nb_r     <= s5_nb_r;
    end
  end

  // stage 7: full products
  logic [FW-1:0]        s7_ac_r, s7_bb_r;
  logic [TW-1:0]        s7_am_r;
  logic                 s7_aneg_r, s7_acneg_r;
  logic signed [TW-1:0] s7_nb_r;
  fbik_pkg::arm_stat_t  s7_st_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s7_ac_r    <= s6_ac_cat_r + (FW'(s6_ac_mid_r) << EW);
      s7_bb_r    <= s6_bb_cat_r + (FW'(s6_bb_mid_r) << EW);
      s7_am_r    <= s6_am_r;
      s7_aneg_r  <= s6_aneg_r;
      s7_acneg_r <= s6_acneg_r;
      s7_nb_r    <= s6_nb_r;
    end
  end

  // stage 8: discriminant
  logic signed [DW-1:0] ac4, bbx, s8_d_nxt;
  logic signed [DW-1:0] s8_d_r;
  logic [TW-1:0]        s8_am_r;
  logic                 s8_aneg_r;
  logic signed [TW-1:0] s8_nb_r;
  fbik_pkg::arm_stat_t  s8_st_r, s8_st_nxt;

  always_comb begin
    ac4 = signed'({2'b00, s7_ac_r, 2'b00});
    bbx = signed'(DW'(s7_bb_r));
    if (s7_acneg_r) begin
      s8_d_nxt = bbx + ac4;
    end else begin
      s8_d_nxt = bbx - ac4;
    end
    s8_st_nxt         = s7_st_r;
    s8_st_nxt.unreach = s8_d_nxt[DW-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_d_r    <= s8_d_nxt;
      s8_am_r   <= s7_am_r;
      s8_aneg_r <= s7_aneg_r;
      s8_nb_r   <= s7_nb_r;
    end
  end

  // square root, one result bit per stage
  logic [RMW-1:0]       sq_rem_r  [RW];
  logic [RW-1:0]        sq_root_r [RW];
  logic [DW-1:0]        sq_rad_r  [RW];
  logic [TW-1:0]        sq_am_r   [RW];
  logic                 sq_aneg_r [RW];
  logic signed [TW-1:0] sq_nb_r   [RW];
  fbik_pkg::arm_stat_t  sq_st_r   [RW];

  for (genvar k = 0; k < RW; k++) begin : g_sq
    logic [RMW-1:0]       rem_i, rem_sh, trial;
    logic [RW-1:0]        root_i;
    logic [DW-1:0]        rad_i;
    logic [TW-1:0]        am_i;
    logic                 aneg_i, ge;
    logic signed [TW-1:0] nb_i;
    fbik_pkg::arm_stat_t  st_i;

    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = s8_d_r;
      assign am_i   = s8_am_r;
      assign aneg_i = s8_aneg_r;
      assign nb_i   = s8_nb_r;
      assign st_i   = s8_st_r;
    end else begin : g_next
      assign rem_i  = sq_rem_r[k-1];
      assign root_i = sq_root_r[k-1];
      assign rad_i  = sq_rad_r[k-1];
      assign am_i   = sq_am_r[k-1];
      assign aneg_i = sq_aneg_r[k-1];
      assign nb_i   = sq_nb_r[k-1];
      assign st_i   = sq_st_r[k-1];
    end

    assign rem_sh = {rem_i[RMW-3:0], rad_i[DW-1 -: 2]};
    assign trial  = {root_i, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_st_r[k] <= '0;
      end else if (en) begin
        sq_st_r[k] <= st_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem_r[k]  <= ge ? (rem_sh - trial) : rem_sh;
        sq_root_r[k] <= {root_i[RW-2:0], ge};
        sq_rad_r[k]  <= rad_i << 2;
        sq_am_r[k]   <= am_i;
        sq_aneg_r[k] <= aneg_i;
        sq_nb_r[k]   <= nb_i;
      end
    end
  end

  // numerator
  logic signed [NW-1:0] nbx, rtx;
  logic signed [NW-1:0] n1_nn_r;
  logic [TW-1:0]        n1_am_r;
  logic                 n1_aneg_r;
  fbik_pkg::arm_stat_t  n1_st_r;

  assign nbx = NW'(sq_nb_r[RW-1]);
  assign rtx = signed'(NW'(sq_root_r[RW-1]));

  always_ff @(posedge clk) begin
    if (en) begin
      n1_nn_r   <= RIGHT ? (nbx - rtx) : (nbx + rtx);
      n1_am_r   <= sq_am_r[RW-1];
      n1_aneg_r <= sq_aneg_r[RW-1];
    end
  end

  // vector operands
  logic [NW-1:0]       n2_mx_r, n2_my_r;
  logic                n2_yneg_r;
  fbik_pkg::arm_stat_t n2_st_r;

  always_ff @(posedge clk) begin
    if (en) begin
      n2_mx_r   <= NW'({n1_am_r, 1'b0});
      n2_my_r   <= n1_nn_r[NW-1] ? NW'(-n1_nn_r) : NW'(n1_nn_r);
      n2_yneg_r <= (n1_nn_r != '0) && (n1_nn_r[NW-1] ^ n1_aneg_r);
    end
  end

  // normalization, one shift size per stage
  logic [NW-1:0]       nm_mx_r   [L];
  logic [NW-1:0]       nm_my_r   [L];
  logic                nm_yneg_r [L];
  fbik_pkg::arm_stat_t nm_st_r   [L];

  for (genvar j = 0; j < L; j++) begin : g_nm
    localparam int SH = 1 << (L - 1 - j);
    logic [NW-1:0]       mx_i, my_i, m_i;
    logic                yneg_i, lz;
    fbik_pkg::arm_stat_t st_i;

    if (j == 0) begin : g_first
      assign mx_i   = n2_mx_r;
      assign my_i   = n2_my_r;
      assign yneg_i = n2_yneg_r;
      assign st_i   = n2_st_r;
    end else begin : g_next
      assign mx_i   = nm_mx_r[j-1];
      assign my_i   = nm_my_r[j-1];
      assign yneg_i = nm_yneg_r[j-1];
      assign st_i   = nm_st_r[j-1];
    end

    assign m_i = mx_i | my_i;
    assign lz  = (m_i[NW-1 -: SH] == '0);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        nm_st_r[j] <= '0;
      end else if (en) begin
        nm_st_r[j] <= st_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nm_mx_r[j]   <= lz ? (mx_i << SH) : mx_i;
        nm_my_r[j]   <= lz ? (my_i << SH) : my_i;
        nm_yneg_r[j] <= yneg_i;
      end
    end
  end

  // vectoring CORDIC
  logic signed [CXW-1:0] co_x_r [CS];
  logic signed [CXW-1:0] co_y_r [CS];
  logic signed [ZW-1:0]  co_z_r [CS];
  fbik_pkg::arm_stat_t   co_st_r [CS];
  logic signed [CXW-1:0] xm0, ym0;

  assign xm0 = signed'(CXW'(nm_mx_r[L-1][NW-1 -: MW]));
  assign ym0 = signed'(CXW'(nm_my_r[L-1][NW-1 -: MW]));

  for (genvar i = 0; i < CS; i++) begin : g_co
    logic signed [CXW-1:0] x_i, y_i, dx, dy;
    logic signed [ZW-1:0]  z_i, at;
    fbik_pkg::arm_stat_t   st_i;

    if (i == 0) begin : g_first
      assign x_i  = xm0;
      assign y_i  = nm_yneg_r[L-1] ? -ym0 : ym0;
      assign z_i  = '0;
      assign st_i = nm_st_r[L-1];
    end else begin : g_next
      assign x_i  = co_x_r[i-1];
      assign y_i  = co_y_r[i-1];
      assign z_i  = co_z_r[i-1];
      assign st_i = co_st_r[i-1];
    end

    assign dx = y_i >>> i;
    assign dy = x_i >>> i;
    assign at = signed'(ZW'(fbik_pkg::ATAN_TAB[i]));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        co_st_r[i] <= '0;
      end else if (en) begin
        co_st_r[i] <= st_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!y_i[CXW-1]) begin
          co_x_r[i] <= x_i + dx;
          co_y_r[i] <= y_i - dy;
          co_z_r[i] <= z_i + at;
        end else begin
          co_x_r[i] <= x_i - dx;
          co_y_r[i] <= y_i + dy;
          co_z_r[i] <= z_i - at;
        end
      end
    end
  end

  // doubled angle, rounded
  logic [ZW:0]         t_nxt;
  logic [AW-1:0]       fin_ang_r;
  fbik_pkg::arm_stat_t fin_st_r;

  assign t_nxt = {co_z_r[CS-1], 1'b0} + RND;

  always_ff @(posedge clk) begin
    if (en) begin
      fin_ang_r <= t_nxt[SHA +: AW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_st_r  <= '0;
      s2_st_r  <= '0;
      s3_st_r  <= '0;
      s4_st_r  <= '0;
      s5_st_r  <= '0;
      s6_st_r  <= '0;
      s7_st_r  <= '0;
      s8_st_r  <= '0;
      n1_st_r  <= '0;
      n2_st_r  <= '0;
      fin_st_r <= '0;
    end else if (en) begin
      s1_st_r  <= s1_st_nxt;
      s2_st_r  <= s1_st_r;
      s3_st_r  <= s2_st_r;
      s4_st_r  <= s4_st_nxt;
      s5_st_r  <= s4_st_r;
      s6_st_r  <= s5_st_r;
      s7_st_r  <= s6_st_r;
      s8_st_r  <= s8_st_nxt;
      n1_st_r  <= sq_st_r[RW-1];
      n2_st_r  <= n1_st_r;
      fin_st_r <= co_st_r[CS-1];
    end
  end

  assign res   = fin_st_r;
  assign angle = fin_ang_r;

endmodule

>>> sv/five_bar_inverse_kinematics_unit.sv
// ----------------------------------------------------------------------------
// Five-bar linkage inverse kinematics unit
// Solves both crank angles of a five-bar linkage for a target point.
//
//   channel  direction  ports                                        transfer when
//   in       input      in_target_x, in_target_y                     in_valid & in_ready
//   out      output     out_left_angle, out_right_angle, out_status  out_valid & out_ready
//   cfg      input      cfg_index, cfg_data                          cfg_valid & cfg_ready
//
// One point per cycle while no result waits. The square-root section has R stages,
// R = 2*max(COORD_WIDTH,18) + 10, and the normalizer has N stages, N the log2 of
// the numerator width. The square-root pipeline sets the depth.
// Reset clears the valid bits and the link registers; cfg_ready is always high.
// A waiting result freezes the whole pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module five_bar_inverse_kinematics_unit #(
  parameter int COORD_WIDTH   = 20,
  parameter int ANGLE_WIDTH   = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [COORD_WIDTH-1:0]         in_target_x,
  input  logic signed [COORD_WIDTH-1:0]         in_target_y,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [ANGLE_WIDTH-1:0]         out_left_angle,
  output logic signed [ANGLE_WIDTH-1:0]         out_right_angle,
  output logic [fbik_pkg::STATUS_W-1:0]         out_status,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [fbik_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [fbik_pkg::LEN_W-1:0]            cfg_data
);

  logic [fbik_pkg::LEN_W-1:0] left_crank_r, left_distal_r;
  logic [fbik_pkg::LEN_W-1:0] right_distal_r, right_crank_r, base_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_crank_r   <= '0;
      left_distal_r  <= '0;
      right_distal_r <= '0;
      right_crank_r  <= '0;
      base_r         <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fbik_pkg::CFG_LEFT_CRANK:   left_crank_r   <= cfg_data;
        fbik_pkg::CFG_LEFT_DISTAL:  left_distal_r  <= cfg_data;
        fbik_pkg::CFG_RIGHT_DISTAL: right_distal_r <= cfg_data;
        fbik_pkg::CFG_RIGHT_CRANK:  right_crank_r  <= cfg_data;
        fbik_pkg::CFG_BASE:         base_r         <= cfg_data;
        default: ;
      endcase
    end
  end

  logic                          adv;
  fbik_pkg::arm_stat_t           l_res, r_res;
  logic [ANGLE_WIDTH-1:0]        l_ang, r_ang;

  logic                          out_valid_r;
  logic [ANGLE_WIDTH-1:0]        out_left_angle_r, out_right_angle_r;
  logic [fbik_pkg::STATUS_W-1:0] out_status_r, status_nxt;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  fbik_arm #(
    .CW(COORD_WIDTH), .AW(ANGLE_WIDTH), .CS(CORDIC_STAGES), .RIGHT(1'b0)
  ) u_left (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(in_valid),
    .x(in_target_x), .y(in_target_y), .base(base_r),
    .crank(left_crank_r), .distal(left_distal_r),
    .res(l_res), .angle(l_ang)
  );

  fbik_arm #(
    .CW(COORD_WIDTH), .AW(ANGLE_WIDTH), .CS(CORDIC_STAGES), .RIGHT(1'b1)
  ) u_right (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(in_valid),
    .x(in_target_x), .y(in_target_y), .base(base_r),
    .crank(right_crank_r), .distal(right_distal_r),
    .res(r_res), .angle(r_ang)
  );

  always_comb begin
    if (l_res.unreach) begin
      status_nxt = fbik_pkg::ST_LEFT_UNREACH;
    end else if (l_res.degen) begin
      status_nxt = fbik_pkg::ST_DEGENERATE;
    end else if (r_res.unreach) begin
      status_nxt = fbik_pkg::ST_RIGHT_UNREACH;
    end else if (r_res.degen) begin
      status_nxt = fbik_pkg::ST_DEGENERATE;
    end else begin
      status_nxt = fbik_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= l_res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_status_r      <= status_nxt;
      out_left_angle_r  <= (status_nxt == fbik_pkg::ST_OK) ? l_ang : '0;
      out_right_angle_r <= (status_nxt == fbik_pkg::ST_OK) ? r_ang : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_left_angle  = signed'(out_left_angle_r);
  assign out_right_angle = signed'(out_right_angle_r);
  assign out_status      = out_status_r;

  logic                           out_fail, out_angles_zero, cfg_skip;
  logic [5*fbik_pkg::LEN_W-1:0]   links_all;

  assign out_fail        = out_valid_r && (out_status_r != fbik_pkg::ST_OK);
  assign out_angles_zero = (out_left_angle_r == '0) && (out_right_angle_r == '0);
  assign cfg_skip        = cfg_valid && cfg_ready && (cfg_index > fbik_pkg::CFG_BASE);
  assign links_all       = {base_r, left_crank_r, left_distal_r, right_crank_r, right_distal_r};

  `FBIK_ASSERT_ALWAYS(a_arm_lockstep, l_res.valid == r_res.valid, "arm valid bits diverged")
  `FBIK_ASSERT_IMPLIES(a_fail_zero, out_fail, out_angles_zero, "failed solve with nonzero angle")
  `FBIK_ASSERT_NEXT(a_cfg_ignore, cfg_skip, $stable(links_all), "stray write changed a link")

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Five-bar IK unit testbench
// Streams target points through the solver under several link setups and
// checks both crank angles and the status against a bit-exact predictor of
// the discriminant, square-root root choice and vectoring arctangent.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class ik_scoreboard;
  logic [17:0] links [5];
  logic [15:0] exp_left [$];
  logic [15:0] exp_right [$];
  logic [1:0]  exp_status [$];
  int          errors;

  function new();
    foreach (links[i]) links[i] = '0;
    errors = 0;
  endfunction

  // atan2(-/+ny, ux) for ux >= 0, 2^32 units per turn
  function longint cordic_atan(longint ux, longint ny, bit yneg);
    longint m, x, y, z, dx, dy;
    int i;
    m = (ux > ny) ? ux : ny;
    z = 0;
    if (m == 0) return 0;
    while (m >= (64'sd1 <<< 41)) begin
      ux = ux >>> 1; ny = ny >>> 1; m = m >>> 1;
    end
    while (m < (64'sd1 <<< 40)) begin
      ux = ux <<< 1; ny = ny <<< 1; m = m <<< 1;
    end
    x = ux;
    y = yneg ? -ny : ny;
    for (i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + fbik_pkg::ATAN_TAB[i];
      end else begin
        x = x - dx; y = y + dy; z = z - fbik_pkg::ATAN_TAB[i];
      end
    end
    return z;
  endfunction

  function logic [1:0] solve_arm(longint cx, longint cy, longint r, longint d, bit minus,
                                 output logic [15:0] ang);
    logic signed [127:0] a, c, b, disc, s, cand, n, u;
    longint t;
    int i;
    ang = '0;
    a = (cx + r) * (cx + r) + cy * cy - d * d;
    c = (cx - r) * (cx - r) + cy * cy - d * d;
    b = -4 * r * cy;
    disc = b * b - 4 * a * c;
    if (disc < 0) return fbik_pkg::ST_LEFT_UNREACH;
    if (a == 0) return fbik_pkg::ST_DEGENERATE;
    s = 0;
    for (i = 63; i >= 0; i--) begin
      cand = s | (128'sd1 <<< i);
      if (cand * cand <= disc) s = cand;
    end
    n = minus ? (-b - s) : (-b + s);
    u = 2 * a;
    if (u < 0) begin
      u = -u; n = -n;
    end
    t = 2 * cordic_atan(longint'(u), longint'(n < 0 ? -n : n), n < 0) + (64'sd1 <<< 15);
    ang = 16'(t >>> 16);
    return fbik_pkg::ST_OK;
  endfunction

  function void note_point(logic signed [19:0] tx, logic signed [19:0] ty);
    logic [15:0] la, ra;
    logic [1:0]  st;
    longint px, py, base;
    px = tx; py = ty; base = links[fbik_pkg::CFG_BASE];
    st = solve_arm(2 * px + base, 2 * py, 2 * longint'(links[fbik_pkg::CFG_LEFT_CRANK]),
                   2 * longint'(links[fbik_pkg::CFG_LEFT_DISTAL]), 1'b0, la);
    if (st == fbik_pkg::ST_OK) begin
      st = solve_arm(2 * px - base, 2 * py, 2 * longint'(links[fbik_pkg::CFG_RIGHT_CRANK]),
                     2 * longint'(links[fbik_pkg::CFG_RIGHT_DISTAL]), 1'b1, ra);
      if (st == fbik_pkg::ST_LEFT_UNREACH) st = fbik_pkg::ST_RIGHT_UNREACH;
    end
    if (st != fbik_pkg::ST_OK) begin
      la = '0; ra = '0;
    end
    exp_left.push_back(la);
    exp_right.push_back(ra);
    exp_status.push_back(st);
  endfunction

  function void check_angles(logic [15:0] la, logic [15:0] ra, logic [1:0] st);
    logic [15:0] el, er;
    logic [1:0]  es;
    if (exp_status.size() == 0) begin
      $error("unexpected result transfer: left %0d right %0d status %0d", la, ra, st);
      errors++;
      return;
    end
    el = exp_left.pop_front();
    er = exp_right.pop_front();
    es = exp_status.pop_front();
    if (la !== el) begin
      $error("left_angle expected %0d actual %0d", $signed(el), $signed(la)); errors++;
    end
    if (ra !== er) begin
      $error("right_angle expected %0d actual %0d", $signed(er), $signed(ra)); errors++;
    end
    if (st !== es) begin
      $error("status expected %0d actual %0d", es, st); errors++;
    end
  endfunction
endclass

module tb_top;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  logic signed [19:0] in_target_x, in_target_y;
  logic signed [15:0] out_left_angle, out_right_angle;
  logic [fbik_pkg::STATUS_W-1:0] out_status;
  logic [fbik_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [fbik_pkg::LEN_W-1:0] cfg_data;

  ik_scoreboard sb = new();
  int  points_sent = 0;
  bit  held_off = 0;
  int  hold_cnt = 0;
  int  stall_mode = 0;

  five_bar_inverse_kinematics_unit dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      sb.note_point(in_target_x, in_target_y);
      points_sent++;
    end
    if (rst_n && out_valid && out_ready)
      sb.check_angles(out_left_angle, out_right_angle, out_status);
  end

  // receiver: one long hold-off, otherwise a phase-dependent stall pattern
  always @(posedge clk) begin
    if (!held_off && points_sent >= 700) begin
      held_off <= 1;
      hold_cnt <= 600;
      out_ready <= 0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 0;
    end else begin
      case (stall_mode)
        0: out_ready <= 1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  task automatic write_link(logic [fbik_pkg::CFG_IDX_W-1:0] idx,
                            logic [fbik_pkg::LEN_W-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.links[idx] = val;
  endtask

  task automatic set_links(int lc, int ld, int rd, int rc, int bl);
    write_link(fbik_pkg::CFG_LEFT_CRANK, 18'(lc));
    write_link(fbik_pkg::CFG_LEFT_DISTAL, 18'(ld));
    write_link(fbik_pkg::CFG_RIGHT_DISTAL, 18'(rd));
    write_link(fbik_pkg::CFG_RIGHT_CRANK, 18'(rc));
    write_link(fbik_pkg::CFG_BASE, 18'(bl));
    cfg_valid <= 0;
  endtask

  task automatic send_point(logic signed [19:0] tx, logic signed [19:0] ty);
    in_valid <= 1;
    in_target_x <= tx;
    in_target_y <= ty;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic pause_sender();
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.exp_status.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic random_points(int count);
    int reach, burst, k;
    logic signed [19:0] tx, ty;
    reach = sb.links[fbik_pkg::CFG_LEFT_CRANK] + sb.links[fbik_pkg::CFG_LEFT_DISTAL] + 16;
    if (reach > 524287) reach = 524287;
    k = 0;
    while (k < count) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && k < count) begin
        if ($urandom_range(0, 4) == 0) begin
          tx = 20'($urandom);
          ty = 20'($urandom);
        end else begin
          tx = 20'($signed($urandom_range(0, 2 * reach)) - reach);
          ty = 20'($signed($urandom_range(0, reach + reach / 4)) - reach / 4);
        end
        send_point(tx, ty);
        burst--; k++;
      end
      pause_sender();
    end
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0; in_target_x = '0; in_target_y = '0;
    out_ready = 0; cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // reset links: everything collapses onto the pivots
    send_point(0, 0);
    send_point(-524288, 524287);
    send_point(524287, -524288);
    send_point(1, -1);
    drain();

    set_links(6400, 9600, 9600, 6400, 4000);
    send_point(0, 12000);
    send_point(0, 14000);
    send_point(3000, 9000);
    send_point(-3000, 9000);
    send_point(0, 100000);
    send_point(0, -12000);
    send_point(524287, 524287);
    send_point(-524288, -524288);
    pause_sender();
    random_points(350);
    drain();

    // equal crank and distal with no base: zero leading coefficient at the origin
    stall_mode = 1;
    set_links(6400, 6400, 6400, 6400, 0);
    send_point(0, 0);
    send_point(0, 6400);
    random_points(200);
    drain();

    stall_mode = 2;
    set_links(6400, 9600, 3000, 6400, 4000);
    send_point(0, 12000);
    send_point(-2000, 10000);
    random_points(350);
    drain();

    stall_mode = 1;
    set_links(262143, 262143, 262143, 262143, 262143);
    send_point(0, 400000);
    send_point(524287, 0);
    send_point(-524288, 524287);
    random_points(350);
    drain();

    stall_mode = 0;
    set_links(1, 1, 1, 1, 0);
    send_point(0, 0);
    send_point(1, 1);
    random_points(150);
    drain();

    stall_mode = 2;
    set_links(9000, 12000, 12000, 9000, 262143);
    random_points(400);
    drain();

    if (sb.errors == 0 && sb.exp_status.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule

>>> filelist.f
+incdir+sv
sv/fbik_pkg.sv
sv/fbik_arm.sv
sv/five_bar_inverse_kinematics_unit.sv
tb/sv/tb_top.sv
